// ===== rtl/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants for the bit packed pixel unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int CMP_W       = (DIM_W + 1 > 13) ? DIM_W + 1 : 13;
   localparam int MAX_RESULTS = 8;
   localparam int RES_W       = $clog2(MAX_RESULTS);
   localparam int BUF_W       = 15;
   localparam int CNT_W       = 4;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
   localparam logic [2:0] REG_BITS_FIRST    = 3'd3;
   localparam logic [2:0] REG_BITS_SECOND   = 3'd4;
   localparam logic [2:0] REG_BITS_THIRD    = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] sample;
      logic [1:0] channel;
      logic       pixel_end;
      logic       frame_end;
      logic       last;
   } rsp_type;

   // clamped configuration as seen by the sequencer
   typedef struct packed {
      logic [CMP_W-1:0] width_lim;
      logic [CMP_W-1:0] height_lim;
      logic [1:0]       chans;
      logic [3:0]       w0;
      logic [3:0]       w1;
      logic [3:0]       w2;
   } cfg_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       extract;
      logic [7:0] data_byte;
      logic [3:0] width;
   } unit_ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0]       sample;
   } unit_stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXTRACT
   } seq_state_type;

endpackage

// ===== rtl/bpu_csr.sv =====
// ----------------------------------------------------------------------------
// bpu_csr
// Configuration registers behind the APB-style port, with clamped outputs.
// ----------------------------------------------------------------------------
module bpu_csr import bpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [12:0] width_ff,  width_in;
   logic [12:0] height_ff, height_in;
   logic [1:0]  chans_ff,  chans_in;
   logic [3:0]  w0_ff, w0_in;
   logic [3:0]  w1_ff, w1_in;
   logic [3:0]  w2_ff, w2_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   function automatic logic [CMP_W-1:0] clamp_dim(input logic [12:0] v);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(v);
      if (ext == '0) begin
         return CMP_W'(1);
      end else if (ext > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return ext;
   endfunction

   function automatic logic [3:0] clamp_bits(input logic [3:0] v);
      if (v == 4'd0) begin
         return 4'd1;
      end else if (v > 4'd8) begin
         return 4'd8;
      end
      return v;
   endfunction

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[4:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chans_in  = chans_ff;
      w0_in     = w0_ff;
      w1_in     = w1_ff;
      w2_in     = w2_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FRAME_WIDTH:   width_in  = pwdata[12:0];
            REG_FRAME_HEIGHT:  height_in = pwdata[12:0];
            REG_CHANNEL_COUNT: chans_in  = pwdata[1:0];
            REG_BITS_FIRST:    w0_in     = pwdata[3:0];
            REG_BITS_SECOND:   w1_in     = pwdata[3:0];
            REG_BITS_THIRD:    w2_in     = pwdata[3:0];
            default:           width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         chans_ff  <= 2'd3;
         w0_ff     <= 4'd8;
         w1_ff     <= 4'd8;
         w2_ff     <= 4'd8;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chans_ff  <= chans_in;
         w0_ff     <= w0_in;
         w1_ff     <= w1_in;
         w2_ff     <= w2_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FRAME_WIDTH:   prdata = DATA_W'(width_ff);
         REG_FRAME_HEIGHT:  prdata = DATA_W'(height_ff);
         REG_CHANNEL_COUNT: prdata = DATA_W'(chans_ff);
         REG_BITS_FIRST:    prdata = DATA_W'(w0_ff);
         REG_BITS_SECOND:   prdata = DATA_W'(w1_ff);
         REG_BITS_THIRD:    prdata = DATA_W'(w2_ff);
         default:           prdata = '0;
      endcase
   end

   always_comb begin
      cfg.width_lim  = clamp_dim(width_ff);
      cfg.height_lim = clamp_dim(height_ff);
      cfg.chans      = (chans_ff == 2'd0) ? 2'd1 : chans_ff;
      cfg.w0         = clamp_bits(w0_ff);
      cfg.w1         = clamp_bits(w1_ff);
      cfg.w2         = clamp_bits(w2_ff);
   end

endmodule

// ===== rtl/bpu_field_unit.sv =====
// ----------------------------------------------------------------------------
// bpu_field_unit
// Bit buffer with one shared field extractor: loads a byte above the held
// bits, or takes one field off the low end per cycle.
// ----------------------------------------------------------------------------
module bpu_field_unit import bpu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  unit_ctrl_type ctrl,
   output unit_stat_type stat
);

   logic [BUF_W-1:0] buffer_ff, buffer_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [BUF_W-1:0] base_buf;
   logic [CNT_W-1:0] base_cnt;

   always_comb begin
      base_buf  = ctrl.clear ? '0 : buffer_ff;
      base_cnt  = ctrl.clear ? '0 : count_ff;
      buffer_in = buffer_ff;
      count_in  = count_ff;
      if (ctrl.load) begin
         buffer_in = base_buf | (BUF_W'(ctrl.data_byte) << base_cnt[2:0]);
         count_in  = base_cnt + CNT_W'(8);
      end else if (ctrl.extract) begin
         buffer_in = buffer_ff >> ctrl.width;
         count_in  = count_ff - ctrl.width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff <= '0;
         count_ff  <= '0;
      end else begin
         buffer_ff <= buffer_in;
         count_ff  <= count_in;
      end
   end

   // left-align the low field: bits above the field fall off the top
   always_comb begin
      stat.count  = count_ff;
      stat.sample = buffer_ff[7:0] << (4'd8 - ctrl.width);
   end

endmodule

// ===== rtl/bpu_seq.sv =====
// ----------------------------------------------------------------------------
// bpu_seq
// Sequencer: walks channels, columns and rows, drives the field unit one
// field per cycle unless a stalled result holds it, and holds the result register.
// ----------------------------------------------------------------------------
module bpu_seq import bpu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   input  req_type       req_data,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   output unit_ctrl_type ctrl,
   input  unit_stat_type stat
);

   seq_state_type    state_ff, state_in;
   logic [1:0]       ch_ff,    ch_in;
   logic [DIM_W-1:0] col_ff,   col_in;
   logic [DIM_W-1:0] row_ff,   row_in;
   logic             done_ff,  done_in;
   logic [RES_W-1:0] n_ff,     n_in;
   rsp_type          rsp_ff,   rsp_in;
   logic             rvalid_ff, rvalid_in;

   logic             accept;
   logic             drop;
   logic             advance;
   logic [3:0]       w_cur;
   logic [3:0]       w_next;
   logic [1:0]       ch_nxt;
   logic             pend;
   logic             wrap;
   logic             fend;
   logic             more;
   logic [CMP_W-1:0] col_inc;
   logic [CMP_W-1:0] row_inc;
   logic [CNT_W-1:0] rem;

   function automatic logic [3:0] sel_width(input logic [1:0] ch, input cfg_type c);
      case (ch)
         2'd0:    return c.w0;
         2'd1:    return c.w1;
         default: return c.w2;
      endcase
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign drop      = done_ff & ~req_data.frame_start;
   assign advance   = ~rvalid_ff | ~rsp_stall;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

   // field and position arithmetic for the current channel
   always_comb begin
      w_cur   = sel_width(ch_ff, cfg);
      pend    = ({1'b0, ch_ff} + 3'd1) >= {1'b0, cfg.chans};
      ch_nxt  = pend ? 2'd0 : ch_ff + 2'd1;
      w_next  = sel_width(ch_nxt, cfg);
      col_inc = CMP_W'(col_ff) + CMP_W'(1);
      row_inc = CMP_W'(row_ff) + CMP_W'(1);
      wrap    = col_inc >= cfg.width_lim;
      fend    = pend & wrap & (row_inc >= cfg.height_lim);
      rem     = stat.count - w_cur;
      more    = ~fend & (n_ff != RES_W'(MAX_RESULTS - 1)) & (rem >= CNT_W'(w_next));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !drop) begin
               state_in = ST_EXTRACT;
            end
         end
         ST_EXTRACT: begin
            if (advance && !more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath register updates
   always_comb begin
      ctrl.clear     = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.extract   = 1'b0;
      ctrl.data_byte = req_data.data_byte;
      ctrl.width     = w_cur;
      ch_in          = ch_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      done_in        = done_ff;
      n_in           = n_ff;
      rsp_in         = rsp_ff;
      rvalid_in      = rvalid_ff & rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.clear = req_data.frame_start;
               ctrl.load  = ~drop;
               n_in       = '0;
               if (req_data.frame_start) begin
                  ch_in   = '0;
                  col_in  = '0;
                  row_in  = '0;
                  done_in = 1'b0;
               end
            end
         end
         ST_EXTRACT: begin
            if (advance) begin
               ctrl.extract     = 1'b1;
               rsp_in.sample    = stat.sample;
               rsp_in.channel   = ch_ff;
               rsp_in.pixel_end = pend;
               rsp_in.frame_end = fend;
               rsp_in.last      = ~more;
               rvalid_in        = 1'b1;
               n_in             = n_ff + RES_W'(1);
               ch_in            = ch_nxt;
               if (pend) begin
                  if (wrap) begin
                     col_in = '0;
                     row_in = row_inc[DIM_W-1:0];
                     done_in = fend;
                  end else begin
                     col_in = col_inc[DIM_W-1:0];
                  end
               end
            end
         end
         default: begin
            rvalid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ch_ff     <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         done_ff   <= 1'b0;
         n_ff      <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ch_ff     <= ch_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
         n_ff      <= n_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/bit_packed_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// bit_packed_pixel_unpacker
// Unpacks a bit packed byte stream into per-channel 8 bit samples.
//
//   channel  direction  ports                       payload
//   req      in         req_valid/req_stall         req_type  (byte, frame start)
//   rsp      out        rsp_valid/rsp_stall         rsp_type  (sample and flags)
//   csr      in/out     psel/penable/pwrite/paddr   32 bit registers at 4*i
//
// A byte is loaded, then yields 1 to 8 samples, one per cycle while the result
// register is not stalled; a byte after the frame is done is dropped unloaded.
// The field unit takes one field per cycle, which sets that rate.
// Synchronous reset clears all state but the result payload register; there is no clearing pass.
// A stalled result holds the sequencer; req_stall is high while a byte is unpacked.
// ----------------------------------------------------------------------------
module bit_packed_pixel_unpacker import bpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type       cfg;
   unit_ctrl_type ctrl;
   unit_stat_type stat;

   bpu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpu_field_unit u_field (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   bpu_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ctrl      (ctrl),
      .stat      (stat)
   );

endmodule

// ===== rtl/bpu_checker.sv =====
// ----------------------------------------------------------------------------
// bpu_checker
// Port level checks for the bit packed pixel unpacker.
// ----------------------------------------------------------------------------
module bpu_checker import bpu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // a frame start transaction is always unpacked
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.frame_start |=> req_stall)
      else $error("frame start transaction not unpacked");

   // end of frame closes the pixel and the byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.pixel_end && rsp_data.last)
      else $error("frame end without pixel end or last");

   // third channel always ends a pixel, no fourth channel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.channel != 2'd3 &&
                    (rsp_data.channel != 2'd2 || rsp_data.pixel_end))
      else $error("bad channel sequencing");

endmodule

bind bit_packed_pixel_unpacker bpu_checker u_bpu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/tb_bit_packed_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// tb_bit_packed_pixel_unpacker
// Self-checking bench for the bit packed pixel unpacker. Bytes are sent with
// random gaps and every transaction is run through a behavioural predictor of
// the bit buffer, channel walk and pixel counters. Each sample that leaves the
// block is compared field by field with the oldest predicted one. Directed
// tests cover reset values, out of range sizes and widths, single bit fields,
// dropped bytes after the frame and register changes mid-frame. A random phase
// follows with frames under changing settings, plus noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bit_packed_pixel_unpacker;
   import bpu_pkg::*;

   localparam int LIMIT       = 400000;
   localparam int IDLE_TAIL   = 12;
   localparam int MAX_WAIT    = 4;
   localparam int BYTE_TARGET = 350;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // register shadow
   logic [12:0] cfg_width  = 13'd1;
   logic [12:0] cfg_height = 13'd1;
   logic [1:0]  cfg_chans  = 2'd3;
   logic [3:0]  cfg_bits0  = 4'd8;
   logic [3:0]  cfg_bits1  = 4'd8;
   logic [3:0]  cfg_bits2  = 4'd8;

   // unpacker state as predicted
   int unsigned buf_bits   = 0;
   int unsigned buf_count  = 0;
   int unsigned chan_idx   = 0;
   int unsigned col_pos    = 0;
   int unsigned row_pos    = 0;
   bit          frame_over = 1'b0;

   rsp_type     expected_samples[$];
   int unsigned live_bytes     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned rsp_hold       = 0;
   bit          steady         = 1'b0;

   bit_packed_pixel_unpacker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int unsigned eff_dim(input logic [12:0] v);
      if (v == 13'd0) return 1;
      if (v > 13'(MAX_DIM)) return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic int unsigned eff_chans();
      return (cfg_chans == 2'd0) ? 1 : 32'(cfg_chans);
   endfunction

   function automatic int unsigned field_bits(input int unsigned ch);
      logic [3:0] w;
      w = (ch == 0) ? cfg_bits0 : (ch == 1) ? cfg_bits1 : cfg_bits2;
      if (w == 4'd0) return 1;
      if (w > 4'd8) return 8;
      return 32'(w);
   endfunction

   function automatic logic [12:0] pick_dim(input int unsigned hi);
      case ($urandom_range(0, 11))
         0: return 13'd0;
         1: return 13'd8191;
         2: return 13'(MAX_DIM);
         3: return 13'($urandom_range(0, 8191));
         default: return 13'($urandom_range(1, hi));
      endcase
   endfunction

   function automatic logic [3:0] pick_bits();
      if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(1, 8));
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic fs);
      int unsigned fw;
      int unsigned ch;
      int unsigned val;
      int unsigned n;
      rsp_type     s;
      live_bytes++;
      if (fs) begin
         buf_bits   = 0;
         buf_count  = 0;
         chan_idx   = 0;
         col_pos    = 0;
         row_pos    = 0;
         frame_over = 1'b0;
      end
      if (frame_over) return;
      buf_bits  = (buf_bits | (32'(b) << (buf_count & 7))) & 32'h7fff;
      buf_count += 8;
      n = 0;
      while (!frame_over && n < MAX_RESULTS) begin
         ch = chan_idx & 3;
         fw = field_bits(ch);
         if (buf_count < fw) break;
         val       = buf_bits & ((32'd1 << fw) - 1);
         buf_bits  = buf_bits >> fw;
         buf_count -= fw;
         s           = '0;
         s.sample    = 8'((val << (8 - fw)) & 32'hff);
         s.channel   = 2'(ch);
         s.pixel_end = (ch + 1 >= eff_chans());
         if (s.pixel_end) begin
            chan_idx = 0;
            col_pos++;
            if (col_pos >= eff_dim(cfg_width)) begin
               col_pos = 0;
               row_pos++;
               if (row_pos >= eff_dim(cfg_height)) begin
                  frame_over  = 1'b1;
                  s.frame_end = 1'b1;
               end
            end
         end else begin
            chan_idx = ch + 1;
         end
         expected_samples.push_back(s);
         n++;
      end
      if (n > 0) begin
         s      = expected_samples[expected_samples.size() - 1];
         s.last = 1'b1;
         expected_samples[expected_samples.size() - 1] = s;
      end
   endtask

   task automatic check_sample(input rsp_type got);
      rsp_type want;
      if (expected_samples.size() == 0) begin
         if (mismatch_count < 10)
            $display("unexpected sample: %02h ch %0d pix %b frm %b last %b",
                     got.sample, got.channel, got.pixel_end, got.frame_end, got.last);
         mismatch_count++;
      end else begin
         want = expected_samples.pop_front();
         if (got.sample !== want.sample || got.channel !== want.channel ||
             got.pixel_end !== want.pixel_end || got.frame_end !== want.frame_end ||
             got.last !== want.last) begin
            if (mismatch_count < 10)
               $display("mismatch: exp %02h/%0d/%b/%b/%b got %02h/%0d/%b/%b/%b",
                        want.sample, want.channel, want.pixel_end, want.frame_end,
                        want.last, got.sample, got.channel, got.pixel_end,
                        got.frame_end, got.last);
            mismatch_count++;
         end
      end
   endtask

   // result side: accept, check, then hold off for a random count
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_sample(rsp_data);
            rsp_hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:   cfg_width  = value[12:0];
         REG_FRAME_HEIGHT:  cfg_height = value[12:0];
         REG_CHANNEL_COUNT: cfg_chans  = value[1:0];
         REG_BITS_FIRST:    cfg_bits0  = value[3:0];
         REG_BITS_SECOND:   cfg_bits1  = value[3:0];
         REG_BITS_THIRD:    cfg_bits2  = value[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_layout(input logic [12:0] w, input logic [12:0] h,
                               input logic [1:0] c, input logic [3:0] b0,
                               input logic [3:0] b1, input logic [3:0] b2);
      write_csr(REG_FRAME_WIDTH, 32'(w));
      write_csr(REG_FRAME_HEIGHT, 32'(h));
      write_csr(REG_CHANNEL_COUNT, 32'(c));
      write_csr(REG_BITS_FIRST, 32'(b0));
      write_csr(REG_BITS_SECOND, 32'(b1));
      write_csr(REG_BITS_THIRD, 32'(b2));
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fs);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, frame_start: fs};
      do @(posedge clock); while (req_stall);
      predict_byte(b, fs);
   endtask

   // drop valid and wait for every predicted sample, then let the block settle
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic test_default_frame();
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'ha5, 1'b0);
      send_byte(8'h3c, 1'b0);   // frame done, dropped
      send_byte(8'h81, 1'b1);
      settle_idle();
   endtask

   task automatic test_single_bit_fields();
      // zero channel count and zero width act as one, oversized frame
      write_layout(13'd8191, 13'd8191, 2'd0, 4'd0, 4'd1, 4'd1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      settle_idle();
   endtask

   task automatic test_wide_fields();
      // widths above eight act as eight, zero sizes act as one
      write_layout(13'd0, 13'd0, 2'd3, 4'd15, 4'd9, 4'd12);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hfe, 1'b0);
      send_byte(8'h7f, 1'b0);
      settle_idle();
   endtask

   task automatic test_mixed_widths();
      int i;
      write_layout(13'd2, 13'd2, 2'd3, 4'd5, 4'd6, 4'd5);
      for (i = 0; i < 9; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
      settle_idle();
   endtask

   task automatic test_config_mid_frame();
      write_layout(13'd3, 13'd2, 2'd3, 4'd4, 4'd4, 4'd4);
      send_byte(8'h21, 1'b1);
      settle_idle();
      // channel index now above the channel count
      write_csr(REG_CHANNEL_COUNT, 32'd1);
      send_byte(8'h43, 1'b0);
      settle_idle();
      // column now above the row width
      write_csr(REG_FRAME_WIDTH, 32'd1);
      send_byte(8'h65, 1'b0);
      settle_idle();
   endtask

   task automatic test_random_frames();
      int unsigned frames;
      int unsigned nbytes;
      int unsigned px;
      int unsigned bpp;
      int unsigned f;
      int unsigned i;
      int unsigned c;
      logic        fs;
      while (live_bytes < BYTE_TARGET) begin
         steady = ($urandom_range(0, 3) == 0);
         write_layout(pick_dim(4), pick_dim(3),
                      ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                      pick_bits(), pick_bits(), pick_bits());
         frames = $urandom_range(1, 3);
         for (f = 0; f < frames; f++) begin
            px  = eff_dim(cfg_width) * eff_dim(cfg_height);
            bpp = 0;
            for (c = 0; c < eff_chans(); c++) bpp += field_bits(c);
            if (px > 16) nbytes = $urandom_range(3, 10);
            else nbytes = (px * bpp + 7) / 8 + $urandom_range(0, 2);
            for (i = 0; i < nbytes; i++) begin
               if (i == 0) fs = ($urandom_range(0, 5) != 0);
               else fs = ($urandom_range(0, 24) == 0);
               send_byte(8'($urandom_range(0, 255)), fs);
            end
         end
         settle_idle();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_frame();
      test_single_bit_fields();
      test_wide_fields();
      test_mixed_widths();
      test_config_mid_frame();
      test_random_frames();
      settle_idle();
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== bit_packed_pixel_unpacker.f =====
rtl/bpu_pkg.sv
rtl/bpu_csr.sv
rtl/bpu_field_unit.sv
rtl/bpu_seq.sv
rtl/bit_packed_pixel_unpacker.sv
rtl/bpu_checker.sv
verif/tb_bit_packed_pixel_unpacker.sv
